// ----- hw/rtl/sfla_pkg.sv -----
package sfla_pkg;

    // converter and reference resolution
    localparam int ADC_BITS        = 12;
    localparam int SINE_TABLE_BITS = 10;

    // fixed-point alignment shifts
    localparam int X_SHIFT   = 24 - ADC_BITS;
    localparam int EC_SHIFT  = 40 - 2 * ADC_BITS;
    localparam int VPP_SHIFT = 18 - ADC_BITS;
    localparam int XD_W      = 22;

    // wide signed type for intermediate sums
    typedef logic signed [69:0] t_wide;

    localparam logic signed [33:0] TWO_PI_Q28   = 34'sd1686629713;
    localparam logic signed [34:0] CORDIC_K_Q30 = 35'sd652032874;
    localparam logic [6:0]         CORDIC_STEPS = 7'd24;
    localparam logic [6:0]         DIV_STEPS    = 7'd80;
    localparam logic [31:0]        FREQ_MIN_Q16 = 32'd5898240;
    localparam logic [31:0]        FREQ_MAX_Q16 = 32'd3604480000;
    localparam logic [20:0]        VPP_MAX      = 21'h1F_FFFF;
    localparam logic [16:0]        LP_MAX       = 17'd65536;
    localparam t_wide              S32_MAX      = 70'sd2147483647;
    localparam t_wide              S32_MIN      = -70'sd2147483648;
    localparam t_wide              EC_MAX       = 70'sd2147483647;
    localparam t_wide              EC_MIN       = -70'sd2147483647;

    // reset values of the configuration registers
    localparam logic [15:0] RST_DC_OFFSET   = 16'd0;
    localparam logic [23:0] RST_SAMPLE_RATE = 24'd500000;
    localparam logic [15:0] RST_INIT_FREQ   = 16'd1000;
    localparam logic [15:0] RST_SOGI_GAIN   = 16'd23168;
    localparam logic [31:0] RST_PROP_GAIN   = 32'd13107200;
    localparam logic [24:0] RST_INTEG_GAIN  = 25'd83886;
    localparam logic [16:0] RST_LOWPASS     = 17'd328;

    // arctangent of 2^-k in units of 2^-32 turn, padded past the last step
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DC_OFFSET   = 3'd0,
        CFG_SAMPLE_RATE = 3'd1,
        CFG_INIT_FREQ   = 3'd2,
        CFG_SOGI_GAIN   = 3'd3,
        CFG_PROP_GAIN   = 3'd4,
        CFG_INTEG_GAIN  = 3'd5,
        CFG_LOWPASS     = 3'd6
    } t_cfg_idx;

    // multiplier operations in sequence order
    typedef enum logic [3:0] {
        OP_FPI, OP_WQ, OP_WA1, OP_GW, OP_GE, OP_EB, OP_KI,
        OP_KP, OP_XS, OP_LI, OP_XC, OP_LQ, OP_II, OP_QQ
    } t_op;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_COR  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [11:0] adc_sample;
        logic        block_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        frequency_est;
        logic [20:0]        vpp_codes;
        logic signed [15:0] phase_est;
    } t_out_item;

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input t_wide v);
        if (v > S32_MAX) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < S32_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // round Q5.30 to Q1.15 with symmetric clamp
    function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
        logic signed [35:0] r;
        r = (36'(v) + 36'sd16384) >>> 15;
        if (r > 36'sd32767) begin
            return 16'sh7FFF;
        end
        if (r < -36'sd32767) begin
            return 16'sh8001;
        end
        return r[15:0];
    endfunction

endpackage

// ----- hw/rtl/sogi_fll_lock_in_analyzer_top.sv -----
// SOGI-FLL lock-in analyzer.
// Input channel i_in_valid/o_in_ready carries one ADC sample request with a
// block_end flag. Output channel o_out_valid/i_out_ready carries one result
// (frequency Q16.16, peak-to-peak amplitude, phase) for each request flagged
// block_end; other requests give no result.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// A write of the initial frequency reloads the loop and filter state. A
// request is worked on by one shared 34x34 multiplier, a bit-serial divider
// (used twice per sample for the normalized frequency and the DDS step) and
// a 24-step CORDIC. A sample occupies the block until its work is done, and
// no new request is taken before then; a block_end sample adds the magnitude
// square root (32 steps) and the phase CORDIC. The two divisions set the
// rate. The result sits in an output register: the next sample is accepted
// while it waits, and only a second result waits for a stalled receiver.
// Reset (synchronous, active low) loads the register defaults and clears the
// loop state; the block is ready in the cycle after reset.
module sogi_fll_lock_in_analyzer_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sfla_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sfla_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    // configuration registers
    logic [15:0] r_dc_offset;
    logic [23:0] r_sample_rate;
    logic [15:0] r_sogi_gain;
    logic [31:0] r_prop_gain;
    logic [24:0] r_integ_gain;
    logic [16:0] r_lowpass;

    // loop and filter state
    logic signed [31:0] r_sd, r_sq, r_li, r_if, r_qf;
    logic [31:0]        r_freq;
    logic [63:0]        r_dds;

    // sequencer
    sfla_pkg::t_state r_state;
    sfla_pkg::t_op    r_op;
    logic             r_mph;
    logic [6:0]       r_cnt;
    logic             r_div2;
    logic             r_vec;
    logic             r_end;

    // working registers
    logic signed [31:0] r_x, r_w, r_a1, r_b1, r_err, r_gw, r_ec, r_mi, r_mq;
    logic signed [15:0] r_sn, r_cs;
    logic signed [67:0] r_mp;
    logic [79:0]        r_dvd;
    logic [23:0]        r_rem;
    logic [63:0]        r_quo;
    logic signed [34:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_flip, r_zero;
    logic [63:0]        r_n, r_root, r_bit;
    logic [20:0]        r_vpp;
    logic signed [15:0] r_phase;

    // output register
    logic                r_out_valid;
    sfla_pkg::t_out_item r_out;

    logic [23:0]        fs;
    logic [16:0]        lp;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [24:0]        rem_sh, rem_nx;
    logic               div_ge;
    logic signed [34:0] cx_sh, cy_sh;
    logic signed [33:0] cat;
    logic               cpos;
    logic [63:0]        sq_t;
    logic               sq_ge;
    logic [63:0]        dds_nx;
    logic [31:0]        ang, ang_f;
    logic               ang_flip;
    sfla_pkg::t_wide    ec_w, f_sum;
    logic [31:0]        f_cl;
    logic [31:0]        ph_r;
    logic signed [sfla_pkg::XD_W-1:0] xdiff;

    // effective divisor and smoothing coefficient
    assign fs = (r_sample_rate == '0) ? 24'd1 : r_sample_rate;
    assign lp = (r_lowpass > sfla_pkg::LP_MAX) ? sfla_pkg::LP_MAX : r_lowpass;

    // offset-removed sample in Q6.16, shifted to Q4.28 when loaded into r_x
    assign xdiff = $signed((sfla_pkg::XD_W)'({i_in_data.adc_sample[sfla_pkg::ADC_BITS-1:0],
                                               4'b0000}))
                 - $signed((sfla_pkg::XD_W)'(r_dc_offset));

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            sfla_pkg::OP_FPI: begin
                mul_a = {2'b00, r_freq};
                mul_b = sfla_pkg::TWO_PI_Q28;
            end
            sfla_pkg::OP_WQ: begin
                mul_a = 34'(r_w);
                mul_b = 34'(r_sq);
            end
            sfla_pkg::OP_WA1: begin
                mul_a = 34'(r_w);
                mul_b = 34'(r_a1);
            end
            sfla_pkg::OP_GW: begin
                mul_a = {18'b0, r_sogi_gain};
                mul_b = 34'(r_w);
            end
            sfla_pkg::OP_GE: begin
                mul_a = 34'(r_gw);
                mul_b = 34'(r_err);
            end
            sfla_pkg::OP_EB: begin
                mul_a = 34'(r_err);
                mul_b = 34'(r_b1);
            end
            sfla_pkg::OP_KI: begin
                mul_a = {9'b0, r_integ_gain};
                mul_b = 34'(r_ec);
            end
            sfla_pkg::OP_KP: begin
                mul_a = {2'b00, r_prop_gain};
                mul_b = 34'(r_ec);
            end
            sfla_pkg::OP_XS: begin
                mul_a = 34'(r_x);
                mul_b = 34'(r_sn);
            end
            sfla_pkg::OP_LI: begin
                mul_a = {17'b0, lp};
                mul_b = 34'(r_mi) - 34'(r_if);
            end
            sfla_pkg::OP_XC: begin
                mul_a = 34'(r_x);
                mul_b = 34'(r_cs);
            end
            sfla_pkg::OP_LQ: begin
                mul_a = {17'b0, lp};
                mul_b = 34'(r_mq) - 34'(r_qf);
            end
            sfla_pkg::OP_II: begin
                mul_a = 34'(r_if);
                mul_b = 34'(r_if);
            end
            sfla_pkg::OP_QQ: begin
                mul_a = 34'(r_qf);
                mul_b = 34'(r_qf);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // restoring divider step
    assign rem_sh = {r_rem, r_dvd[79]};
    assign div_ge = (rem_sh >= {1'b0, fs});
    assign rem_nx = div_ge ? (rem_sh - {1'b0, fs}) : rem_sh;

    // cordic micro-rotation, shared by rotation and vectoring
    assign cx_sh = r_cx >>> r_cnt[4:0];
    assign cy_sh = r_cy >>> r_cnt[4:0];
    assign cat   = {2'b00, sfla_pkg::ATAN_TURNS[r_cnt[4:0]]};
    assign cpos  = r_vec ? (r_cy[34] || (r_cy == '0)) : !r_cz[33];

    // square root digit step
    assign sq_t  = r_root + r_bit;
    assign sq_ge = (r_n >= sq_t);

    // phase accumulator and reference angle with half-turn fold
    assign dds_nx   = r_dds + r_quo;
    assign ang      = {dds_nx[63 -: sfla_pkg::SINE_TABLE_BITS],
                       (32 - sfla_pkg::SINE_TABLE_BITS)'(0)};
    assign ang_flip = ang[31] ^ ang[30];
    assign ang_f    = ang_flip ? {~ang[31], ang[30:0]} : ang;

    // loop error and frequency update
    assign ec_w  = (-sfla_pkg::t_wide'(r_mp)) >>> sfla_pkg::EC_SHIFT;
    assign f_sum = sfla_pkg::t_wide'(r_freq) + (sfla_pkg::t_wide'(r_mp) >>> 16)
                 + (sfla_pkg::t_wide'(r_li) >>> 12);
    always_comb begin
        if (f_sum > sfla_pkg::t_wide'(sfla_pkg::FREQ_MAX_Q16)) begin
            f_cl = sfla_pkg::FREQ_MAX_Q16;
        end else if (f_sum < sfla_pkg::t_wide'(sfla_pkg::FREQ_MIN_Q16)) begin
            f_cl = sfla_pkg::FREQ_MIN_Q16;
        end else begin
            f_cl = f_sum[31:0];
        end
    end

    // rounded phase from vectoring angle
    assign ph_r = (r_zero ? 32'd0 : r_cz[31:0]) + 32'h0000_8000;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset   <= sfla_pkg::RST_DC_OFFSET;
            r_sample_rate <= sfla_pkg::RST_SAMPLE_RATE;
            r_sogi_gain   <= sfla_pkg::RST_SOGI_GAIN;
            r_prop_gain   <= sfla_pkg::RST_PROP_GAIN;
            r_integ_gain  <= sfla_pkg::RST_INTEG_GAIN;
            r_lowpass     <= sfla_pkg::RST_LOWPASS;
            r_sd          <= '0;
            r_sq          <= '0;
            r_li          <= '0;
            r_if          <= '0;
            r_qf          <= '0;
            r_freq        <= {sfla_pkg::RST_INIT_FREQ, 16'b0};
            r_dds         <= '0;
            r_state       <= sfla_pkg::ST_IDLE;
            r_op          <= sfla_pkg::OP_FPI;
            r_mph         <= 1'b0;
            r_cnt         <= '0;
            r_div2        <= 1'b0;
            r_vec         <= 1'b0;
            r_end         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // result taken by the receiver
            if (r_out_valid && i_out_ready && r_state != sfla_pkg::ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                sfla_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= 32'(xdiff) <<< sfla_pkg::X_SHIFT;
                        r_end   <= i_in_data.block_end;
                        r_op    <= sfla_pkg::OP_FPI;
                        r_mph   <= 1'b0;
                        r_state <= sfla_pkg::ST_MUL;
                    end
                end

                sfla_pkg::ST_MUL: begin
                    if (!r_mph) begin
                        r_mp  <= prod;
                        r_mph <= 1'b1;
                    end else begin
                        r_mph <= 1'b0;
                        case (r_op)
                            sfla_pkg::OP_FPI: begin
                                r_dvd   <= {16'b0, r_mp[63:0]};
                                r_rem   <= '0;
                                r_cnt   <= sfla_pkg::DIV_STEPS;
                                r_div2  <= 1'b0;
                                r_state <= sfla_pkg::ST_DIV;
                            end
                            sfla_pkg::OP_WQ: begin
                                r_a1 <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_sd)
                                        + (sfla_pkg::t_wide'(r_mp) >>> 28));
                                r_op <= sfla_pkg::OP_WA1;
                            end
                            sfla_pkg::OP_WA1: begin
                                r_b1  <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_sq)
                                         - (sfla_pkg::t_wide'(r_mp) >>> 28));
                                r_err <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_x)
                                         - sfla_pkg::t_wide'(r_a1));
                                r_op  <= sfla_pkg::OP_GW;
                            end
                            sfla_pkg::OP_GW: begin
                                r_gw <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_mp) >>> 14);
                                r_op <= sfla_pkg::OP_GE;
                            end
                            sfla_pkg::OP_GE: begin
                                r_sd <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_a1)
                                        + (sfla_pkg::t_wide'(r_mp) >>> 28));
                                r_sq <= r_b1;
                                r_op <= sfla_pkg::OP_EB;
                            end
                            sfla_pkg::OP_EB: begin
                                if (ec_w > sfla_pkg::EC_MAX) begin
                                    r_ec <= sfla_pkg::EC_MAX[31:0];
                                end else if (ec_w < sfla_pkg::EC_MIN) begin
                                    r_ec <= sfla_pkg::EC_MIN[31:0];
                                end else begin
                                    r_ec <= ec_w[31:0];
                                end
                                r_op <= sfla_pkg::OP_KI;
                            end
                            sfla_pkg::OP_KI: begin
                                r_li <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_li)
                                        + (sfla_pkg::t_wide'(r_mp) >>> 12));
                                r_op <= sfla_pkg::OP_KP;
                            end
                            sfla_pkg::OP_KP: begin
                                r_freq  <= f_cl;
                                r_dvd   <= {f_cl, 48'b0};
                                r_rem   <= '0;
                                r_cnt   <= sfla_pkg::DIV_STEPS;
                                r_div2  <= 1'b1;
                                r_state <= sfla_pkg::ST_DIV;
                            end
                            sfla_pkg::OP_XS: begin
                                r_mi <= r_mp[15 +: 32];
                                r_op <= sfla_pkg::OP_LI;
                            end
                            sfla_pkg::OP_LI: begin
                                r_if <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_if)
                                        + (sfla_pkg::t_wide'(r_mp) >>> 16));
                                r_op <= sfla_pkg::OP_XC;
                            end
                            sfla_pkg::OP_XC: begin
                                r_mq <= r_mp[15 +: 32];
                                r_op <= sfla_pkg::OP_LQ;
                            end
                            sfla_pkg::OP_LQ: begin
                                r_qf <= sfla_pkg::sat32(sfla_pkg::t_wide'(r_qf)
                                        + (sfla_pkg::t_wide'(r_mp) >>> 16));
                                if (r_end) begin
                                    r_op <= sfla_pkg::OP_II;
                                end else begin
                                    r_state <= sfla_pkg::ST_IDLE;
                                end
                            end
                            sfla_pkg::OP_II: begin
                                r_n  <= r_mp[63:0];
                                r_op <= sfla_pkg::OP_QQ;
                            end
                            sfla_pkg::OP_QQ: begin
                                r_n     <= r_n + r_mp[63:0];
                                r_root  <= '0;
                                r_bit   <= 64'h4000_0000_0000_0000;
                                r_state <= sfla_pkg::ST_SQRT;
                            end
                            default: begin
                                r_state <= sfla_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end

                sfla_pkg::ST_DIV: begin
                    if (r_cnt != '0) begin
                        r_rem <= rem_nx[23:0];
                        r_quo <= {r_quo[62:0], div_ge};
                        r_dvd <= {r_dvd[78:0], 1'b0};
                        r_cnt <= r_cnt - 7'd1;
                    end else if (!r_div2) begin
                        // normalized frequency, saturated
                        r_w     <= (|r_quo[63:47]) ? 32'sh7FFF_FFFF
                                                   : $signed({1'b0, r_quo[46:16]});
                        r_op    <= sfla_pkg::OP_WQ;
                        r_state <= sfla_pkg::ST_MUL;
                    end else begin
                        // step the dds and start the sine/cosine rotation
                        r_dds   <= dds_nx;
                        r_cx    <= sfla_pkg::CORDIC_K_Q30;
                        r_cy    <= '0;
                        r_cz    <= 34'($signed(ang_f));
                        r_flip  <= ang_flip;
                        r_vec   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= sfla_pkg::ST_COR;
                    end
                end

                sfla_pkg::ST_COR: begin
                    if (r_cnt != sfla_pkg::CORDIC_STEPS) begin
                        r_cx  <= cpos ? (r_cx - cy_sh) : (r_cx + cy_sh);
                        r_cy  <= cpos ? (r_cy + cx_sh) : (r_cy - cx_sh);
                        r_cz  <= cpos ? (r_cz - cat) : (r_cz + cat);
                        r_cnt <= r_cnt + 7'd1;
                    end else if (!r_vec) begin
                        r_sn    <= sfla_pkg::to_q15(r_flip ? -r_cy : r_cy);
                        r_cs    <= sfla_pkg::to_q15(r_flip ? -r_cx : r_cx);
                        r_op    <= sfla_pkg::OP_XS;
                        r_state <= sfla_pkg::ST_MUL;
                    end else begin
                        r_phase <= $signed(ph_r[31:16]);
                        r_state <= sfla_pkg::ST_OUT;
                    end
                end

                sfla_pkg::ST_SQRT: begin
                    if (r_bit != '0) begin
                        if (sq_ge) begin
                            r_n    <= r_n - sq_t;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        // amplitude, then set up the phase vectoring
                        r_vpp <= (|r_root[63:sfla_pkg::VPP_SHIFT+21]) ? sfla_pkg::VPP_MAX
                                 : r_root[sfla_pkg::VPP_SHIFT +: 21];
                        r_cx    <= r_if[31] ? -35'(r_if) : 35'(r_if);
                        r_cy    <= r_if[31] ? -35'(r_qf) : 35'(r_qf);
                        r_cz    <= r_if[31] ? 34'h0_8000_0000 : 34'h0;
                        r_zero  <= (r_if == '0) && (r_qf == '0);
                        r_vec   <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= sfla_pkg::ST_COR;
                    end
                end

                sfla_pkg::ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.frequency_est <= r_freq;
                        r_out.vpp_codes     <= r_vpp;
                        r_out.phase_est     <= r_phase;
                        r_out_valid         <= 1'b1;
                        r_state             <= sfla_pkg::ST_IDLE;
                    end
                end

                default: begin
                    r_state <= sfla_pkg::ST_IDLE;
                end
            endcase

            // configuration writes
            if (i_cfg_we) begin
                unique case (sfla_pkg::t_cfg_idx'(i_cfg_idx))
                    sfla_pkg::CFG_DC_OFFSET:   r_dc_offset   <= i_cfg_data[15:0];
                    sfla_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[23:0];
                    sfla_pkg::CFG_INIT_FREQ: begin
                        r_freq <= {i_cfg_data[15:0], 16'b0};
                        r_sd   <= '0;
                        r_sq   <= '0;
                        r_li   <= '0;
                        r_if   <= '0;
                        r_qf   <= '0;
                        r_dds  <= '0;
                    end
                    sfla_pkg::CFG_SOGI_GAIN:   r_sogi_gain   <= i_cfg_data[15:0];
                    sfla_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                    sfla_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[24:0];
                    sfla_pkg::CFG_LOWPASS:     r_lowpass     <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == sfla_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted sample keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting a sample");

    // frequency is within bounds when the dds step is computed
    a_freq_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::ST_DIV && r_div2) |->
        (r_freq >= sfla_pkg::FREQ_MIN_Q16 && r_freq <= sfla_pkg::FREQ_MAX_Q16))
        else $error("tracked frequency out of bounds");

    // divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::ST_DIV) |-> (r_rem < fs))
        else $error("divider remainder not below divisor");

    // square root fits in 32 bits
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::ST_SQRT && r_bit == '0) |-> (r_root[63:32] == '0))
        else $error("square root wider than 32 bits");

endmodule

// ----- test/tb_sogi_fll_lock_in_analyzer_top.sv -----
module tb_sogi_fll_lock_in_analyzer_top;

    localparam int         HANG_LIMIT = 4000;
    localparam int         SETTLE     = 300;
    localparam int         N_PHASES   = 8;
    localparam int         PHASE_REQS = 105;
    localparam longint     TWO_PI_Q28_L = 64'sd1686629713;
    localparam longint     K_Q30_L      = 64'sd652032874;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    sfla_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    sfla_pkg::t_out_item o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [31:0]         i_cfg_data = '0;

    sogi_fll_lock_in_analyzer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow registers and loop state of the analyzer
    bit [15:0] m_dc;
    bit [23:0] m_fs;
    bit [15:0] m_f0;
    bit [15:0] m_gamma;
    bit [31:0] m_kp;
    bit [24:0] m_ki;
    bit [16:0] m_lp;
    int        m_direct, m_quad, m_integ, m_ifilt, m_qfilt;
    bit [31:0] m_freq;
    bit [63:0] m_dds;

    sfla_pkg::t_out_item pending_results[$];
    int        n_errors = 0;
    int        n_samples = 0;
    int        n_results = 0;
    int        idle_cycles = 0;
    bit        req_taken = 1'b0;
    bit [15:0] ready_pattern = 16'hFFFF;
    bit        gaps_on = 1'b1;
    int        burst_left = 0;

    function automatic longint sat32_l(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic int round_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32767) begin
            r = -32767;
        end
        return int'(r);
    endfunction

    // rotation-mode cordic, angle in 2^-32 turn
    task automatic ref_sincos(input bit [31:0] ang, output int sn, output int cs);
        longint x, y, z, dx, dy;
        bit [31:0] a;
        bit flip;
        x = K_Q30_L;
        y = 0;
        a = ang;
        flip = 1'b0;
        if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(a));
        for (int k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(sfla_pkg::ATAN_TURNS[k]);
            end else begin
                x += dx; y -= dy; z += longint'(sfla_pkg::ATAN_TURNS[k]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endtask

    // vectoring-mode cordic, atan2(q, i) in 2^-32 turn
    function automatic bit [31:0] vector_angle(longint i, longint q);
        longint x, y, dx, dy;
        bit [31:0] z;
        x = i;
        y = q;
        z = '0;
        if (i == 0 && q == 0) begin
            return '0;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x += dx; y -= dy; z = z + sfla_pkg::ATAN_TURNS[k];
            end else begin
                x -= dx; y += dy; z = z - sfla_pkg::ATAN_TURNS[k];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic clear_loop();
        m_direct = 0; m_quad = 0; m_integ = 0; m_ifilt = 0; m_qfilt = 0;
        m_freq = {m_f0, 16'h0};
        m_dds = '0;
    endtask

    task automatic load_defaults();
        m_dc = sfla_pkg::RST_DC_OFFSET; m_fs = sfla_pkg::RST_SAMPLE_RATE;
        m_f0 = sfla_pkg::RST_INIT_FREQ; m_gamma = sfla_pkg::RST_SOGI_GAIN;
        m_kp = sfla_pkg::RST_PROP_GAIN; m_ki = sfla_pkg::RST_INTEG_GAIN;
        m_lp = sfla_pkg::RST_LOWPASS;
        clear_loop();
    endtask

    // advance the tracker by one sample, return the measurement on block end
    task automatic track_sample(input sfla_pkg::t_in_item req, output bit has_res,
                                output sfla_pkg::t_out_item res);
        longint x, w, a1, b1, err, gw, ec, f, mi, mq, lp, iv, qv;
        longint unsigned fs, wu, fn, q1, r1, q2, r2, q3, fcw, mag, vpp;
        bit [31:0] ang, ph, rnd;
        int sn, cs;
        fs = (m_fs == 0) ? 64'd1 : 64'(m_fs);
        x = (longint'(req.adc_sample) * 16 - longint'(m_dc)) <<< sfla_pkg::X_SHIFT;
        fn = 64'(m_freq);
        wu = (fn * 64'(TWO_PI_Q28_L) / fs) >> 16;
        w = (wu > 64'd2147483647) ? 64'sd2147483647 : longint'(wu);
        // second-order integrator
        a1 = sat32_l(m_direct + ((w * m_quad) >>> 28));
        b1 = sat32_l(m_quad - ((w * a1) >>> 28));
        err = sat32_l(x - a1);
        gw = sat32_l((longint'(m_gamma) * w) >>> 14);
        m_direct = int'(sat32_l(a1 + ((gw * err) >>> 28)));
        m_quad = int'(b1);
        // frequency-locked loop
        ec = (-(err * b1)) >>> sfla_pkg::EC_SHIFT;
        if (ec > 64'sd2147483647) ec = 64'sd2147483647;
        if (ec < -64'sd2147483647) ec = -64'sd2147483647;
        m_integ = int'(sat32_l(m_integ + ((longint'(m_ki) * ec) >>> 12)));
        f = longint'(m_freq) + ((longint'(m_kp) * ec) >>> 16) + (longint'(m_integ) >>> 12);
        if (f > longint'(sfla_pkg::FREQ_MAX_Q16)) f = longint'(sfla_pkg::FREQ_MAX_Q16);
        if (f < longint'(sfla_pkg::FREQ_MIN_Q16)) f = longint'(sfla_pkg::FREQ_MIN_Q16);
        m_freq = f[31:0];
        // phase accumulator step
        fn = 64'(m_freq);
        q1 = fn / fs;
        r1 = fn % fs;
        q2 = (r1 << 24) / fs;
        r2 = (r1 << 24) % fs;
        q3 = (r2 << 24) / fs;
        fcw = (q1 << 48) + (q2 << 24) + q3;
        m_dds = m_dds + fcw;
        ang = {m_dds[63:64-sfla_pkg::SINE_TABLE_BITS],
               {(32-sfla_pkg::SINE_TABLE_BITS){1'b0}}};
        ref_sincos(ang, sn, cs);
        // mix and smooth
        mi = (x * sn) >>> 15;
        mq = (x * cs) >>> 15;
        lp = (m_lp > 17'd65536) ? 64'sd65536 : longint'(m_lp);
        m_ifilt = int'(sat32_l(m_ifilt + ((lp * (mi - m_ifilt)) >>> 16)));
        m_qfilt = int'(sat32_l(m_qfilt + ((lp * (mq - m_qfilt)) >>> 16)));
        has_res = req.block_end;
        res = '0;
        if (req.block_end) begin
            iv = m_ifilt;
            qv = m_qfilt;
            mag = int_sqrt(64'(iv * iv) + 64'(qv * qv));
            vpp = mag >> sfla_pkg::VPP_SHIFT;
            if (vpp > 64'(sfla_pkg::VPP_MAX)) vpp = 64'(sfla_pkg::VPP_MAX);
            ph = vector_angle(iv, qv);
            rnd = ph + 32'h8000;
            res.frequency_est = m_freq;
            res.vpp_codes = vpp[20:0];
            res.phase_est = rnd[31:16];
        end
    endtask

    // handshake monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        sfla_pkg::t_out_item want;
        if (i_rst_n) begin
            req_taken = i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result freq=%0d vpp=%0d phase=%0d",
                           o_out_data.frequency_est, o_out_data.vpp_codes,
                           o_out_data.phase_est);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.frequency_est !== want.frequency_est) begin
                        $error("frequency_est expected %0d actual %0d",
                               want.frequency_est, o_out_data.frequency_est);
                        n_errors++;
                    end
                    if (o_out_data.vpp_codes !== want.vpp_codes) begin
                        $error("vpp_codes expected %0d actual %0d",
                               want.vpp_codes, o_out_data.vpp_codes);
                        n_errors++;
                    end
                    if (o_out_data.phase_est !== want.phase_est) begin
                        $error("phase_est expected %0d actual %0d",
                               want.phase_est, o_out_data.phase_est);
                        n_errors++;
                    end
                end
            end
            if (req_taken || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        i_out_ready = ready_pattern[0];
    end

    // send one request; the literal overrides the predicted result when given
    task automatic send_request(input sfla_pkg::t_in_item req, input bit use_lit,
                                input sfla_pkg::t_out_item lit);
        bit has_res;
        sfla_pkg::t_out_item res;
        if (burst_left <= 0) begin
            if (gaps_on) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        track_sample(req, has_res, res);
        if (has_res) begin
            pending_results.push_back(use_lit ? lit : res);
        end
        i_in_data = req;
        i_in_valid = 1'b1;
        do @(negedge i_clk); while (!req_taken);
        burst_left--;
        n_samples++;
    endtask

    // stop sending until every expected result is back and the block is quiet
    task automatic drain_results();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input sfla_pkg::t_cfg_idx idx, input bit [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            sfla_pkg::CFG_DC_OFFSET:   m_dc = val[15:0];
            sfla_pkg::CFG_SAMPLE_RATE: m_fs = val[23:0];
            sfla_pkg::CFG_INIT_FREQ: begin
                m_f0 = val[15:0];
                clear_loop();
            end
            sfla_pkg::CFG_SOGI_GAIN:   m_gamma = val[15:0];
            sfla_pkg::CFG_PROP_GAIN:   m_kp = val;
            sfla_pkg::CFG_INTEG_GAIN:  m_ki = val[24:0];
            sfla_pkg::CFG_LOWPASS:     m_lp = val[16:0];
            default: ;
        endcase
    endtask

    typedef struct {
        bit [11:0]           adc;
        bit                  blk_end;
        bit                  has_lit;
        sfla_pkg::t_out_item lit;
    } t_row;

    // directed rows at reset defaults: a zero sample leaves the loop at rest
    t_row directed_rows[] = '{
        '{12'd0,    1'b1, 1'b1, '{32'd65536000, 21'd0, 16'sd0}},
        '{12'd4095, 1'b0, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd0,    1'b0, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd2048, 1'b1, 1'b0, '0},
        '{12'd1,    1'b0, 1'b0, '0},
        '{12'd4094, 1'b1, 1'b0, '0},
        '{12'd2730, 1'b0, 1'b0, '0},
        '{12'd1365, 1'b1, 1'b0, '0},
        '{12'd2047, 1'b0, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0}
    };

    initial begin
        sfla_pkg::t_in_item req;
        bit [31:0] regs[7];
        int sent, seg_len, end_every, tone_n, fs_hz, fmax;
        real tone_hz, amp, mid, v;
        bit tone;
        load_defaults();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk
        foreach (directed_rows[r]) begin
            req.adc_sample = directed_rows[r].adc;
            req.block_end = directed_rows[r].blk_end;
            send_request(req, directed_rows[r].has_lit, directed_rows[r].lit);
        end

        for (int p = 1; p <= N_PHASES; p++) begin
            drain_results();
            // register settings: extremes first, then random
            if (p == 1) begin
                regs = '{0, 0, 90, 0, 0, 0, 0};
            end else if (p == 2) begin
                regs = '{32'hFFFF, 32'hFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF,
                         32'h1FF_FFFF, 32'h1_FFFF};
            end else if (p == 3) begin
                regs = '{0, 1000, 55000, 23168, 13107200, 16777216, 65536};
            end else begin
                regs[0] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                     : $urandom_range(30000, 36000);
                regs[1] = $urandom_range(0, 2) == 0 ? $urandom_range(1000, 10000000)
                                                     : $urandom_range(1000, 500000);
                regs[2] = $urandom_range(90, 55000);
                regs[3] = $urandom_range(0, 65535);
                regs[4] = $urandom_range(0, 3) == 0 ? $urandom()
                                                     : $urandom_range(0, 30000000);
                regs[5] = $urandom_range(0, 16777216);
                regs[6] = $urandom_range(0, 65536);
            end
            for (int r = 0; r < 7; r++) begin
                write_reg(sfla_pkg::t_cfg_idx'(r), regs[r]);
            end
            gaps_on = (p % 3) != 0;
            ready_pattern = (p % 4 == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
            fs_hz = (m_fs == 0) ? 1 : int'(m_fs);

            // well-formed tone segments mixed with noise
            sent = 0;
            while (sent < PHASE_REQS) begin
                seg_len = $urandom_range(8, 40);
                tone = $urandom_range(0, 9) < 7;
                fmax = fs_hz / 4;
                if (fmax > 55000) fmax = 55000;
                if (fmax < 90) fmax = 90;
                tone_hz = $urandom_range(90, fmax);
                amp = $urandom_range(0, 2047);
                mid = 2048.0 + $urandom_range(0, 200) - 100.0;
                end_every = $urandom_range(4, 24);
                tone_n = 0;
                for (int k = 0; k < seg_len && sent < PHASE_REQS; k++) begin
                    if (tone) begin
                        v = mid + amp * $sin(6.283185307 * tone_hz * tone_n / fs_hz);
                        if (v < 0.0) v = 0.0;
                        if (v > 4095.0) v = 4095.0;
                        req.adc_sample = 12'($rtoi(v));
                        req.block_end = (tone_n % end_every) == end_every - 1;
                        tone_n++;
                    end else begin
                        req.adc_sample = 12'($urandom());
                        req.block_end = $urandom_range(0, 3) == 0;
                    end
                    send_request(req, 1'b0, '0);
                    sent++;
                    // one mid-phase hold until the output side catches up
                    if (p == 4 && sent == 50) begin
                        drain_results();
                    end
                end
            end
        end

        drain_results();
        $display("covered %0d sample requests and %0d measurements over %0d register settings",
                 n_samples, n_results, N_PHASES + 1);
        $display("settings included zero and maximum registers, random stalls and gaps");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
